@@ design/lbp_pkg.sv @@
// ----------------------------------------------------------------------------
// lbp_pkg
// Shared constants, types and helpers for the LSB-first bit packer.
// ----------------------------------------------------------------------------
package lbp_pkg;

    localparam int MAX_FIELD_BITS = 32;
    localparam int VALUE_W        = 32;
    localparam int WIDTH_W        = 6;
    localparam int BYTE_BITS      = 8;
    localparam int FREE_W         = 4;
    localparam int REM_W          = $clog2(MAX_FIELD_BITS + 1);

    // controller -> datapath commands
    typedef struct packed {
        logic load;        // capture an accepted input beat
        logic step;        // pack one chunk into the partial byte
        logic flush_emit;  // emit the partial byte zero padded
    } cmd_t;

    // datapath -> controller status
    typedef struct packed {
        logic rem_zero;       // no bits left to pack
        logic fills;          // next chunk completes the byte
        logic flush_pending;  // flush asked for and bits are pending
        logic slot_free;      // output register can take a beat
    } status_t;

    // low-bit mask for 0..8 bits
    function automatic logic [BYTE_BITS-1:0] mask_of(input logic [FREE_W-1:0] n);
        logic [BYTE_BITS-1:0] m;
        unique case (n)
            4'd0:    m = 8'h00;
            4'd1:    m = 8'h01;
            4'd2:    m = 8'h03;
            4'd3:    m = 8'h07;
            4'd4:    m = 8'h0F;
            4'd5:    m = 8'h1F;
            4'd6:    m = 8'h3F;
            4'd7:    m = 8'h7F;
            4'd8:    m = 8'hFF;
            default: m = 8'hFF;
        endcase
        return m;
    endfunction

endpackage

@@ design/lbp_datapath.sv @@
// ----------------------------------------------------------------------------
// lbp_datapath
// Chunk packer: partial byte, free-bit count, field shifter, output register.
// ----------------------------------------------------------------------------
module lbp_datapath import lbp_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cmd_t                 cmd,
    output status_t              st,
    input  logic [VALUE_W-1:0]   s_value,
    input  logic [WIDTH_W-1:0]   s_width,
    input  logic                 s_flush,
    input  logic                 m_ready,
    output logic                 m_valid,
    output logic [BYTE_BITS-1:0] m_out_byte,
    output logic                 m_last
);

    logic [VALUE_W-1:0]   value_reg;
    logic [REM_W-1:0]     rem_reg;
    logic                 flush_reg;
    logic [BYTE_BITS-1:0] partial_reg;
    logic [FREE_W-1:0]    free_reg;
    logic                 m_valid_reg;
    logic [BYTE_BITS-1:0] out_byte_reg;
    logic                 last_reg;

    logic [REM_W-1:0]     free_ext;
    logic [REM_W-1:0]     take_wide;
    logic [FREE_W-1:0]    take;
    logic [FREE_W-1:0]    pos_wide;
    logic [2:0]           pos;
    logic [BYTE_BITS-1:0] chunk;
    logic [BYTE_BITS-1:0] merged;
    logic [FREE_W-1:0]    free_after;
    logic [REM_W-1:0]     rem_after;
    logic                 last_step;
    logic [REM_W-1:0]     width_sat;

    // widths past the maximum saturate
    assign width_sat = (s_width > WIDTH_W'(MAX_FIELD_BITS)) ? REM_W'(MAX_FIELD_BITS)
                                                             : REM_W'(s_width);

    assign free_ext   = REM_W'(free_reg);
    assign take_wide  = (free_ext < rem_reg) ? free_ext : rem_reg;
    assign take       = take_wide[FREE_W-1:0];
    assign pos_wide   = FREE_W'(BYTE_BITS) - free_reg;
    assign pos        = pos_wide[2:0];
    assign chunk      = value_reg[BYTE_BITS-1:0] & mask_of(take);
    assign merged     = partial_reg | (chunk << pos);
    assign free_after = free_reg - take;
    assign rem_after  = rem_reg - take_wide;
    // no further full byte, and no flush byte to follow
    assign last_step  = (rem_after < REM_W'(BYTE_BITS)) &&
                        !(flush_reg && (rem_after != '0));

    assign st.rem_zero      = (rem_reg == '0);
    assign st.fills         = (free_after == '0);
    assign st.flush_pending = flush_reg && (free_reg != FREE_W'(BYTE_BITS));
    assign st.slot_free     = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            value_reg <= s_value;
            flush_reg <= s_flush;
        end else if (cmd.step) begin
            value_reg <= value_reg >> take;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg     <= '0;
            partial_reg <= '0;
            free_reg    <= FREE_W'(BYTE_BITS);
            m_valid_reg <= 1'b0;
        end else begin
            // a new byte only lands in a free slot
            if ((cmd.step && (free_after == '0)) || cmd.flush_emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cmd.load) begin
                rem_reg <= width_sat;
            end else if (cmd.step) begin
                rem_reg <= rem_after;
                if (free_after == '0) begin
                    partial_reg <= '0;
                    free_reg    <= FREE_W'(BYTE_BITS);
                end else begin
                    partial_reg <= merged;
                    free_reg    <= free_after;
                end
            end else if (cmd.flush_emit) begin
                partial_reg <= '0;
                free_reg    <= FREE_W'(BYTE_BITS);
            end
        end
    end

    // output payload, no reset needed
    always_ff @(posedge aclk) begin
        if (cmd.step && (free_after == '0)) begin
            out_byte_reg <= merged;
            last_reg     <= last_step;
        end else if (cmd.flush_emit) begin
            out_byte_reg <= partial_reg;
            last_reg     <= 1'b1;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_out_byte = out_byte_reg;
    assign m_last     = last_reg;

    a_free_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (free_reg != '0) && (free_reg <= FREE_W'(BYTE_BITS)))
        else $error("free bit count out of range");

    a_partial_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (partial_reg & ~mask_of(FREE_W'(pos))) == '0)
        else $error("partial byte has bits above fill point");

    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        rem_reg <= REM_W'(MAX_FIELD_BITS))
        else $error("remaining bit count past maximum");

endmodule

@@ design/lbp_ctrl.sv @@
// ----------------------------------------------------------------------------
// lbp_ctrl
// Sequencer: accepts a beat, steps the packer chunk by chunk, then sends a flush byte if one is pending.
// ----------------------------------------------------------------------------
module lbp_ctrl import lbp_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  status_t st,
    output cmd_t    cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_PACK = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_PACK;
                end
            end
            S_PACK: begin
                if (st.rem_zero) begin
                    if (!st.flush_pending) begin
                        state_next = S_IDLE;
                    end else if (st.slot_free) begin
                        cmd.flush_emit = 1'b1;
                        state_next     = S_IDLE;
                    end
                end else if (!st.fills || st.slot_free) begin
                    cmd.step = 1'b1;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.step && st.fills) || cmd.flush_emit |-> st.slot_free)
        else $error("byte emitted into a busy output register");

    a_cmd_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.load, cmd.step, cmd.flush_emit}))
        else $error("conflicting datapath commands");

    a_load_pack: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> (state_reg == S_PACK))
        else $error("accepted beat not followed by packing");

endmodule

@@ design/lsb_first_bit_packer.sv @@
// ----------------------------------------------------------------------------
// lsb_first_bit_packer
// LSB-first variable-width bit packer with flush and end-of-beat marking.
// ----------------------------------------------------------------------------
// Each input beat carries a value, a width of 0..32 bits (larger widths are
// clamped to 32) and a flush flag. The low width bits of the value are packed
// least significant bit first into the lowest free positions of the current
// partial byte; each byte that fills leaves on the m_ channel, and a flush
// sends out a pending partial byte zero padded. m_last marks the final byte
// caused by a beat; a beat that causes no byte sends nothing. The sequencer
// accepts the beat, then packs one chunk per step, a chunk being the bits
// that fit in the current byte (at most 5 chunks for 32 bits), then takes a
// closing step that also sends any flush byte. The single chunk shifter
// moves at most one byte's worth of bits per cycle while m_ready does not
// stall; a stalled m_ready holds the packer whenever a completed byte cannot
// be placed. s_ready is low while a beat is being packed; the output
// register lets a new beat be accepted while the last byte still waits to
// be taken.
// ----------------------------------------------------------------------------
module lsb_first_bit_packer import lbp_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    // input beats
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [VALUE_W-1:0]   s_value,
    input  logic [WIDTH_W-1:0]   s_width,
    input  logic                 s_flush,
    // packed byte beats
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [BYTE_BITS-1:0] m_out_byte,
    output logic                 m_last
);

    cmd_t    cmd;
    status_t st;

    // sequencer: accept, step per chunk, optional flush byte
    lbp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .st      (st),
        .cmd     (cmd)
    );

    // packing datapath with its own output register
    lbp_datapath u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .st         (st),
        .s_value    (s_value),
        .s_width    (s_width),
        .s_flush    (s_flush),
        .m_ready    (m_ready),
        .m_valid    (m_valid),
        .m_out_byte (m_out_byte),
        .m_last     (m_last)
    );

endmodule
